// ----- hdl/two_class_sorted_insert_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sorted insert table.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_SORTED_INSERT_TABLE_TOP_MACROS_SVH
`define TWO_CLASS_SORTED_INSERT_TABLE_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCSIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define TCSIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tcsit_pkg.sv -----
// ----------------------------------------------------------------------------
// tcsit_pkg
// Types, codes and the ordering rule of the sorted insert table.
// ----------------------------------------------------------------------------
package tcsit_pkg;

  localparam logic       OP_INSERT    = 1'b0;
  localparam logic       OP_READ      = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic        opcode;
    logic [31:0] frame_handle;
    logic [63:0] frame_time;
    logic        ground_truth;
    logic [7:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_handle;
    logic [63:0]        out_time;
    logic               out_ground_truth;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  // One stored table entry (one RAM word).
  typedef struct packed {
    logic [31:0] frame_handle;
    logic [63:0] frame_time;
    logic        ground_truth;
  } entry_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // True when a new entry (gt, t) must sit ahead of stored entry e.
  // Equal timestamps keep the stored entry first.
  function automatic logic goes_before(entry_t e, logic gt, logic [63:0] t);
    logic later;
    later = e.frame_time > t;
    if (gt) begin
      return !e.ground_truth || later;
    end else begin
      return !e.ground_truth && later;
    end
  endfunction

endpackage

// ----- hdl/tcsit_ram.sv -----
// ----------------------------------------------------------------------------
// tcsit_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcsit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/tcsit_seq.sv -----
// ----------------------------------------------------------------------------
// tcsit_seq
// Sequencer: scans the table from the tail, shifting entries up one slot
// until the insert position is found; serves indexed reads.
// ----------------------------------------------------------------------------
`include "two_class_sorted_insert_table_top_macros.svh"

module tcsit_seq
  import tcsit_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  in_t                            in_data_i,
  input  logic                           slot_free_i,
  output res_t                           res_o,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output entry_t                         ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  entry_t                         ram_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = CW + 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN,
    ST_PLACE,
    ST_PUSH
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [AW-1:0]   ptr_q;
  entry_t          new_q;
  out_t            res_q;

  logic            accept;
  logic            is_read;
  logic            full;
  logic            idx_ok;
  logic            ahead;
  logic [XW-1:0]   idx_ext;
  logic [XW-1:0]   cnt_ext;
  logic [AW-1:0]   tail_addr;
  entry_t          in_entry;
  out_t            acc_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_read    = (in_data_i.opcode == OP_READ);
  assign full       = (count_q == CW'(TABLE_DEPTH));
  assign idx_ext    = XW'(in_data_i.read_index);
  assign cnt_ext    = XW'(count_q);
  assign idx_ok     = idx_ext < cnt_ext;
  assign tail_addr  = count_q[AW-1:0] - AW'(1);
  assign ahead      = goes_before(ram_rdata_i, new_q.ground_truth, new_q.frame_time);

  assign in_entry.frame_handle = in_data_i.frame_handle;
  assign in_entry.frame_time   = in_data_i.frame_time;
  assign in_entry.ground_truth = in_data_i.ground_truth;

  // Result fields known at transfer time; a read fills in its data later.
  always_comb begin
    acc_res        = '0;
    acc_res.status = STATUS_OK;
    if (is_read) begin
      if (!idx_ok) begin
        acc_res.status = STATUS_RANGE;
      end
    end else if (full) begin
      acc_res.status = STATUS_FULL;
    end
  end

  // RAM port control. During the scan the write goes to ptr+1 and the next
  // read to ptr-1, so the two ports never touch the same entry.
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = new_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_read) begin
            ram_re_o    = idx_ok;
            ram_raddr_o = idx_ext[AW-1:0];
          end else if (!full) begin
            if (count_q == '0) begin
              ram_we_o    = 1'b1;
              ram_wdata_o = in_entry;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = tail_addr;
            end
          end
        end
      end
      ST_SCAN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q + AW'(1);
        if (ahead) begin
          ram_wdata_o = ram_rdata_i;
          ram_re_o    = (ptr_q != '0);
          ram_raddr_o = ptr_q - AW'(1);
        end
      end
      ST_PLACE: begin
        ram_we_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      new_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_q <= acc_res;
            new_q <= in_entry;
            if (is_read) begin
              if (idx_ok) begin
                state_q <= ST_RD_WAIT;
              end else begin
                state_q <= ST_PUSH;
              end
            end else if (full) begin
              state_q <= ST_PUSH;
            end else if (count_q == '0) begin
              count_q <= count_q + CW'(1);
              state_q <= ST_PUSH;
            end else begin
              ptr_q   <= tail_addr;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_RD_WAIT: begin
          res_q.out_handle       <= ram_rdata_i.frame_handle;
          res_q.out_time         <= ram_rdata_i.frame_time;
          res_q.out_ground_truth <= ram_rdata_i.ground_truth;
          state_q                <= ST_PUSH;
        end
        ST_SCAN: begin
          if (ahead) begin
            if (ptr_q == '0) begin
              state_q <= ST_PLACE;
            end else begin
              ptr_q <= ptr_q - AW'(1);
            end
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= ST_PUSH;
          end
        end
        ST_PLACE: begin
          count_q <= count_q + CW'(1);
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (slot_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_o.valid            = (state_q == ST_PUSH);
    res_o.data             = res_q;
    res_o.data.entry_count = cnt_ext[COUNT_W-1:0];
  end

  `TCSIT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_DEPTH), "count over depth")
  `TCSIT_ASSERT_IMPL(a_port_split, clk_i, rst_ni, ram_we_o && ram_re_o, ram_waddr_o != ram_raddr_o, "write and read hit same entry")
  `TCSIT_ASSERT_IMPL(a_scan_ptr, clk_i, rst_ni, state_q == ST_SCAN, CW'(ptr_q) < count_q, "scan pointer past fill")
  `TCSIT_ASSERT_IMPL(a_count_step, clk_i, rst_ni, count_q != $past(count_q), count_q == $past(count_q) + CW'(1), "count moved by other than one")

endmodule

// ----- hdl/two_class_sorted_insert_table_top.sv -----
// ----------------------------------------------------------------------------
// two_class_sorted_insert_table_top
// Ordered table of frame entries: ground-truth entries first, each class
// kept in stable ascending timestamp order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): one transfer per
//   item, either an insert (opcode 0) or a read at read_index (opcode 1).
//   Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
//   result transfer per item, in item order, with status and the entry
//   count after the item.
//   Timing: one item is worked on at a time. An insert that shifts
//   entries up has the sequencer walk the table from the tail, one RAM
//   read and one write-back per cycle, so the single read port of the
//   entry RAM sets the cost per moved entry.
//   Reset: the entry count clears to zero; RAM contents are left as they
//   are, since only positions below the count are ever read.
//   Stall: a finished result sits in the output register; the next item is
//   still taken and worked on, and its result waits in the sequencer until
//   the output register frees up.
// ----------------------------------------------------------------------------
module two_class_sorted_insert_table_top
  import tcsit_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // RAM port wiring between sequencer and entry memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  res_t          res;
  logic          slot_free;
  logic          out_valid_q;
  out_t          out_q;

  // Entry store: one word per table position (handle, timestamp, class).
  tcsit_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Scan-and-shift sequencer; holds the fill count.
  tcsit_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res.valid && slot_free) begin
      out_valid_q <= 1'b1;
      out_q       <= res.data;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
